### hdl/msdpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdpu_pkg
// Shared types and constants of the periodic-unwrap mean squared
// displacement core.
// ----------------------------------------------------------------------------
package msdpu_pkg;

  localparam int MaxParticles = 4096;
  localparam int PosW         = 32;
  localparam int WrapW        = 16;
  localparam int AccW         = 64;
  localparam int FrameW       = 16;
  localparam int CntCfgW      = 13;
  localparam int CfgDataW     = 32;
  localparam int CfgIdxW      = 2;
  localparam int CalcCycles   = 6;

  localparam logic [PosW-1:0] BoxReset = 32'd655360;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBoxLength     = 2'd0,
    CfgParticleCount = 2'd1,
    CfgFirstFrame    = 2'd2,
    CfgLastFrame     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic [FrameW-1:0] frame_offset;
    logic [AccW-1:0]   msd_value;
  } out_word_t;

  typedef struct packed {
    logic [PosW-1:0]  ref_x;
    logic [PosW-1:0]  ref_y;
    logic [PosW-1:0]  prev_x;
    logic [PosW-1:0]  prev_y;
    logic [WrapW-1:0] wrap_x;
    logic [WrapW-1:0] wrap_y;
  } mem_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hdl/msdpu_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdpu_axis
// Five-stage pipeline for one axis: wrap detection, box multiple,
// unwrapped displacement, magnitude with saturation, and square.
// ----------------------------------------------------------------------------
module msdpu_axis (
  input  logic                      clk_i,
  input  logic [msdpu_pkg::PosW-1:0]  box_i,
  input  logic [msdpu_pkg::PosW-1:0]  pos_i,
  input  logic [msdpu_pkg::PosW-1:0]  prev_i,
  input  logic [msdpu_pkg::PosW-1:0]  ref_i,
  input  logic [msdpu_pkg::WrapW-1:0] wrap_i,
  output logic [msdpu_pkg::WrapW-1:0] wrap_o,
  output logic [msdpu_pkg::AccW-1:0]  sq_o
);
  import msdpu_pkg::*;

  localparam int DiffW = PosW + 3;
  localparam int ProdW = PosW + 1 + WrapW;
  localparam int UW    = ProdW + 1;

  logic [DiffW-1:0]       diff;
  logic [DiffW-1:0]       d2;
  logic [DiffW-1:0]       box_ext;
  logic [DiffW-1:0]       box_neg;
  logic [WrapW-1:0]       wrap_d;
  logic [WrapW-1:0]       wrap_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [UW-1:0]   u_d;
  logic signed [UW-1:0]   u_q;
  logic [UW-1:0]          mag;
  logic                   sat_d;
  logic                   sat_q;
  logic [PosW-1:0]        mag_d;
  logic [PosW-1:0]        mag_q;
  logic [AccW-1:0]        sq_d;
  logic [AccW-1:0]        sq_q;

  always_comb begin
    diff    = {3'b000, pos_i} - {3'b000, prev_i};
    d2      = {diff[DiffW-2:0], 1'b0};
    box_ext = {3'b000, box_i};
    box_neg = -box_ext;
    if ($signed(d2) <= $signed(box_neg)) begin
      wrap_d = wrap_i + WrapW'(1);
    end else if ($signed(d2) >= $signed(box_ext)) begin
      wrap_d = wrap_i - WrapW'(1);
    end else begin
      wrap_d = wrap_i;
    end
  end

  assign prod_d = $signed({1'b0, box_i}) * $signed(wrap_q);
  assign u_d    = UW'(prod_q) + $signed({{(UW-PosW){1'b0}}, pos_i})
                  - $signed({{(UW-PosW){1'b0}}, ref_i});

  always_comb begin
    mag   = u_q[UW-1] ? UW'(-u_q) : UW'(u_q);
    sat_d = |mag[UW-1:PosW];
    mag_d = mag[PosW-1:0];
  end

  assign sq_d = sat_q ? {AccW{1'b1}} : AccW'(mag_q * mag_q);

  always_ff @(posedge clk_i) begin
    wrap_q <= wrap_d;
    prod_q <= prod_d;
    u_q    <= u_d;
    sat_q  <= sat_d;
    mag_q  <= mag_d;
    sq_q   <= sq_d;
  end

  assign wrap_o = wrap_q;
  assign sq_o   = sq_q;

endmodule

### hdl/msdpu_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdpu_divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msdpu_divider #(
  parameter int DividendW = msdpu_pkg::AccW,
  parameter int DivisorW  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DividendW-1:0]  dividend_i,
  input  logic [DivisorW-1:0]   divisor_i,
  output logic [DividendW-1:0]  quotient_o,
  output msdpu_pkg::div_status_t status_o
);
  import msdpu_pkg::*;

  localparam int StepW = (DividendW > 1) ? $clog2(DividendW) : 1;

  logic                 busy_q;
  logic                 done_q;
  logic [StepW-1:0]     step_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW-1:0]  div_q;
  logic [DivisorW:0]    rem_sh;
  logic                 ge;
  logic [DivisorW:0]    rem_next;

  always_comb begin
    rem_sh   = {rem_q, quo_q[DividendW-1]};
    ge       = rem_sh >= {1'b0, div_q};
    rem_next = ge ? rem_sh - {1'b0, div_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DividendW-2:0], ge};
      rem_q <= rem_next[DivisorW-1:0];
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

### hdl/msd_periodic_unwrap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_periodic_unwrap_core
// Mean squared displacement of 2-D particles in a periodic box, with
// per-particle wrap counters kept in one particle-state memory.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Word
//  in        in_valid_i / in_ready_o   in_data_i  (pos_x, pos_y)
//  out       out_valid_o / out_ready_i out_data_o (frame_offset, msd_value)
//  cfg       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Each word passes the particle-state memory read, the axis unit pipelines
// and the write-back to the same memory entry before the next is taken;
// a word that closes a window frame also waits for the serial divider.
// Reset clears control state only; the reference frame initializes every
// memory entry that later frames read. A word that closes a frame is held
// off while a previous result still waits on the output.
// ----------------------------------------------------------------------------
module msd_periodic_unwrap_core #(
  parameter int MAX_PARTICLES = msdpu_pkg::MaxParticles
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  msdpu_pkg::in_word_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output msdpu_pkg::out_word_t             out_data_o,
  input  logic                             cfg_we_i,
  input  logic [msdpu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [msdpu_pkg::CfgDataW-1:0]   cfg_data_i
);
  import msdpu_pkg::*;

  localparam int IdxW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CntW   = $clog2(MAX_PARTICLES + 1);
  localparam int CalcW  = $clog2(CalcCycles);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StCalc = 4'b0010,
    StAcc  = 4'b0100,
    StDiv  = 4'b1000
  } state_e;

  state_e              state_q;
  logic [PosW-1:0]     box_q;
  logic [CntCfgW-1:0]  count_q;
  logic [FrameW-1:0]   first_q;
  logic [FrameW-1:0]   last_q;
  logic [IdxW-1:0]     pidx_q;
  logic [FrameW-1:0]   frame_q;
  logic [AccW-1:0]     sum_q;
  logic [CalcW-1:0]    calc_q;
  logic                is_ref_q;
  logic                in_win_q;
  logic                closes_q;
  logic [FrameW-1:0]   offset_q;
  in_word_t            item_q;
  mem_word_t           rd_q;
  mem_word_t           wr_word;
  logic                mem_we;
  logic                out_valid_q;
  out_word_t           out_q;
  logic [AccW-1:0]     pair_q;
  logic [AccW:0]       pair_sum;
  logic [AccW:0]       acc_sum;
  logic [AccW-1:0]     sum_d;
  logic [CntW-1:0]     cnt_eff;
  logic                closes;
  logic                accept;
  logic                div_start;
  logic [WrapW-1:0]    wrap_x;
  logic [WrapW-1:0]    wrap_y;
  logic [AccW-1:0]     sq_x;
  logic [AccW-1:0]     sq_y;
  logic [AccW-1:0]     quotient;
  div_status_t         div_status;

  mem_word_t           mem_q [MAX_PARTICLES];

  always_comb begin
    if (count_q == '0) begin
      cnt_eff = CntW'(1);
    end else if (32'(count_q) > 32'(MAX_PARTICLES)) begin
      cnt_eff = CntW'(MAX_PARTICLES);
    end else begin
      cnt_eff = CntW'(count_q);
    end
  end

  assign closes     = (32'(pidx_q) + 32'd1) >= 32'(cnt_eff);
  assign in_ready_o = (state_q == StIdle) && !(out_valid_q && closes);
  assign accept     = in_valid_i && in_ready_o;

  msdpu_axis u_axis_x (
    .clk_i  (clk_i),
    .box_i  (box_q),
    .pos_i  (item_q.pos_x),
    .prev_i (rd_q.prev_x),
    .ref_i  (rd_q.ref_x),
    .wrap_i (rd_q.wrap_x),
    .wrap_o (wrap_x),
    .sq_o   (sq_x)
  );

  msdpu_axis u_axis_y (
    .clk_i  (clk_i),
    .box_i  (box_q),
    .pos_i  (item_q.pos_y),
    .prev_i (rd_q.prev_y),
    .ref_i  (rd_q.ref_y),
    .wrap_i (rd_q.wrap_y),
    .wrap_o (wrap_y),
    .sq_o   (sq_y)
  );

  always_comb begin
    pair_sum = {1'b0, sq_x} + {1'b0, sq_y};
    acc_sum  = {1'b0, sum_q} + {1'b0, pair_q};
    sum_d    = acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
  end

  always_comb begin
    wr_word.ref_x  = is_ref_q ? item_q.pos_x : rd_q.ref_x;
    wr_word.ref_y  = is_ref_q ? item_q.pos_y : rd_q.ref_y;
    wr_word.prev_x = item_q.pos_x;
    wr_word.prev_y = item_q.pos_y;
    wr_word.wrap_x = is_ref_q ? '0 : wrap_x;
    wr_word.wrap_y = is_ref_q ? '0 : wrap_y;
    mem_we         = (state_q == StAcc) && (is_ref_q || in_win_q);
  end

  assign div_start = (state_q == StAcc) && closes_q && in_win_q && !is_ref_q;

  msdpu_divider #(
    .DividendW (AccW),
    .DivisorW  (CntW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_eff),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pidx_q] <= wr_word;
    end
    if (accept) begin
      rd_q <= mem_q[pidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_sum[AccW] ? {AccW{1'b1}} : pair_sum[AccW-1:0];
    if (accept) begin
      item_q   <= in_data_i;
      is_ref_q <= (frame_q == first_q);
      in_win_q <= (frame_q > first_q) && (frame_q <= last_q);
      closes_q <= closes;
      offset_q <= frame_q - first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q   <= BoxReset;
      count_q <= CntCfgW'(1);
      first_q <= '0;
      last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgBoxLength:     box_q   <= cfg_data_i[PosW-1:0];
        CfgParticleCount: count_q <= cfg_data_i[CntCfgW-1:0];
        CfgFirstFrame:    first_q <= cfg_data_i[FrameW-1:0];
        CfgLastFrame:     last_q  <= cfg_data_i[FrameW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      calc_q      <= '0;
      pidx_q      <= '0;
      frame_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            calc_q  <= '0;
            state_q <= StCalc;
          end
        end
        StCalc: begin
          calc_q <= calc_q + CalcW'(1);
          if (calc_q == CalcW'(CalcCycles - 1)) begin
            state_q <= StAcc;
          end
        end
        StAcc: begin
          if (closes_q) begin
            sum_q   <= '0;
            pidx_q  <= '0;
            frame_q <= frame_q + FrameW'(1);
            if (in_win_q && !is_ref_q) begin
              state_q <= StDiv;
            end else begin
              state_q <= StIdle;
            end
            if (is_ref_q) begin
              out_valid_q <= 1'b1;
              out_q       <= '0;
            end
          end else begin
            state_q <= StIdle;
            pidx_q  <= pidx_q + IdxW'(1);
            if (in_win_q && !is_ref_q) begin
              sum_q <= sum_d;
            end
          end
        end
        StDiv: begin
          if (div_status.done) begin
            out_valid_q        <= 1'b1;
            out_q.frame_offset <= offset_q;
            out_q.msd_value    <= quotient;
            state_q            <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
